// ----- rtl/bls_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded LIFO stack engine package
// Shared widths, opcode and status codes, and the decode record that passes
// from the decode logic to the result stage.
// ----------------------------------------------------------------------------
package bls_pkg;

    localparam int CNT_W         = 9;
    localparam int CNT_LIMIT     = 1 << CNT_W;
    localparam int WORD_W        = 32;
    localparam int OP_W          = 4;
    localparam int OFF_W         = 8;
    localparam int ST_W          = 2;
    localparam int IN_TDATA_W    = 56;
    localparam int OUT_TDATA_W   = 48;
    localparam int MAX_SLOTS_DEF = 256;

    localparam logic [CNT_W-1:0] SLOTS_RESET = CNT_W'(256);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH        = 4'd0,
        OP_POP         = 4'd1,
        OP_DUP         = 4'd2,
        OP_DROP        = 4'd3,
        OP_DROP_N      = 4'd4,
        OP_TOP         = 4'd5,
        OP_NOS         = 4'd6,
        OP_PICK        = 4'd7,
        OP_PICK_BOTTOM = 4'd8,
        OP_SET_TOP     = 4'd9,
        OP_SET_BOTTOM  = 4'd10,
        OP_POP_OR_TOP  = 4'd11,
        OP_CLEAR       = 4'd12
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 2'd0,
        ST_UNDER = 2'd1,
        ST_OVER  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        SEL_ZERO  = 2'd0,
        SEL_VALUE = 2'd1,
        SEL_READ  = 2'd2
    } data_sel_t;

    typedef struct packed {
        status_t          status;
        logic [CNT_W-1:0] depth;
        data_sel_t        sel;
        logic [CNT_W-1:0] raddr;
        logic             we;
        logic             wsrc_read;
        logic [CNT_W-1:0] waddr;
    } dec_t;

endpackage
`default_nettype wire

// ----- rtl/bounded_lifo_stack_engine_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded LIFO stack engine
// Each item on the slave stream carries one stack operation; each gives one
// result item on the master stream with the data word, depth and status.
//
// An accepted item is held in an input register, decoded against the
// element count and registered with the store read into the result stage.
// A result is offered once its item has passed the input register and the
// result stage, and the block sustains one item per cycle while the receiver
// takes each result; the store has one read and one write port, with the write of each item forwarded to the next read.
// When the receiver stalls, the result stays put and the input register
// takes one more item before s_tready falls.
// The configuration channel sets the slot count and is always ready.
// Reset empties the stack and sets the slot count to 256; the store itself
// is not cleared, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module bounded_lifo_stack_engine_top #(
    parameter int MAX_SLOTS = bls_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // opcode, value, offset, drop_count, zero_on_empty, zero fill
    input  wire logic [bls_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // data, depth, status, zero fill
    output logic      [bls_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    input  wire logic [bls_pkg::CNT_W-1:0]       cfg_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready
);
    import bls_pkg::*;

    localparam int MemDepth = (MAX_SLOTS < CNT_LIMIT) ? MAX_SLOTS : CNT_LIMIT;

    logic [CNT_W-1:0]  slots_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              a_valid_reg;
    logic [OP_W-1:0]   a_op_reg;
    logic [WORD_W-1:0] a_value_reg;
    logic [OFF_W-1:0]  a_offset_reg;
    logic [CNT_W-1:0]  a_cnt_reg;
    logic              a_zoe_reg;

    logic              b_valid_reg;
    status_t           b_status_reg;
    logic [CNT_W-1:0]  b_depth_reg;
    data_sel_t         b_sel_reg;
    logic [WORD_W-1:0] b_value_reg;
    logic              b_we_reg;
    logic              b_wsrc_reg;
    logic [CNT_W-1:0]  b_waddr_reg;

    dec_t              dec;
    logic              a_adv;
    logic              b_take;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] out_data;

    assign b_take    = b_valid_reg && m_tready;
    assign a_adv     = a_valid_reg && (!b_valid_reg || m_tready);
    assign s_tready  = !a_valid_reg || a_adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg <= SLOTS_RESET;
        end
        else if (cfg_valid)
        begin
            slots_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            count_reg   <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                a_valid_reg <= s_tvalid;
            end
            if (a_adv)
            begin
                b_valid_reg <= 1'b1;
                count_reg   <= dec.depth;
            end
            else if (b_take)
            begin
                b_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            a_op_reg     <= s_tdata[3:0];
            a_value_reg  <= s_tdata[35:4];
            a_offset_reg <= s_tdata[43:36];
            a_cnt_reg    <= s_tdata[52:44];
            a_zoe_reg    <= s_tdata[53];
        end
        if (a_adv)
        begin
            b_status_reg <= dec.status;
            b_depth_reg  <= dec.depth;
            b_sel_reg    <= dec.sel;
            b_value_reg  <= a_value_reg;
            b_we_reg     <= dec.we;
            b_wsrc_reg   <= dec.wsrc_read;
            b_waddr_reg  <= dec.waddr;
        end
    end

    bls_decode #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_decode (
        .op            (a_op_reg),
        .offset        (a_offset_reg),
        .drop_count    (a_cnt_reg),
        .zero_on_empty (a_zoe_reg),
        .count         (count_reg),
        .slots         (slots_reg),
        .dec           (dec)
    );

    bls_store #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_store (
        .clk       (clk),
        .rd_en     (a_adv),
        .raddr     (dec.raddr),
        .wr_en     (b_take && b_we_reg),
        .waddr     (b_waddr_reg),
        .wsrc_read (b_wsrc_reg),
        .wvalue    (b_value_reg),
        .rd_word   (rd_word)
    );

    always_comb
    begin
        unique case (b_sel_reg)
            SEL_VALUE: out_data = b_value_reg;
            SEL_READ:  out_data = rd_word;
            default:   out_data = '0;
        endcase
    end

    assign m_tvalid = b_valid_reg;
    assign m_tdata  = {5'b0, b_status_reg, b_depth_reg, out_data};

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (CNT_W + 1)'(count_reg) <= (CNT_W + 1)'(MemDepth))
        else $error("element count exceeds the store depth");

    a_error_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        a_adv && (dec.status != ST_OK) |=> count_reg == $past(count_reg))
        else $error("failed operation changed the element count");

    a_count_moves_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !a_adv |=> $stable(count_reg))
        else $error("element count changed without an item advancing");

    a_write_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_we_reg |-> b_status_reg == ST_OK)
        else $error("store write requested by a failed operation");
`endif

endmodule
`default_nettype wire

// ----- rtl/bls_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack operation decode
// Works out status, new depth, read address and write request of one item
// from the registered item and the current element count.
// ----------------------------------------------------------------------------
module bls_decode #(
    parameter int MAX_SLOTS = bls_pkg::MAX_SLOTS_DEF
) (
    input  wire logic [bls_pkg::OP_W-1:0]  op,
    input  wire logic [bls_pkg::OFF_W-1:0] offset,
    input  wire logic [bls_pkg::CNT_W-1:0] drop_count,
    input  wire logic                      zero_on_empty,
    input  wire logic [bls_pkg::CNT_W-1:0] count,
    input  wire logic [bls_pkg::CNT_W-1:0] slots,
    output bls_pkg::dec_t                  dec
);
    import bls_pkg::*;

    localparam int MemDepth = (MAX_SLOTS < CNT_LIMIT) ? MAX_SLOTS : CNT_LIMIT;
    localparam logic [CNT_W:0] CapLimit = (CNT_W + 1)'(MemDepth);

    logic [CNT_W-1:0] cap;
    logic [CNT_W-1:0] one;
    logic [CNT_W-1:0] off_ext;
    logic [CNT_W-1:0] after_n;
    logic             empty;
    logic             full;

    assign one     = CNT_W'(1);
    assign off_ext = CNT_W'(offset);
    assign after_n = count - drop_count;
    assign empty   = (count == '0);
    assign cap     = ({1'b0, slots} > CapLimit) ? CapLimit[CNT_W-1:0] : slots;
    assign full    = (count >= cap);

    always_comb
    begin
        dec.status    = ST_OK;
        dec.depth     = count;
        dec.sel       = SEL_ZERO;
        dec.raddr     = count - one;
        dec.we        = 1'b0;
        dec.wsrc_read = 1'b0;
        dec.waddr     = count;
        unique case (opcode_t'(op))
            OP_PUSH:
            begin
                if (full)
                begin
                    dec.status = ST_OVER;
                end
                else
                begin
                    dec.we    = 1'b1;
                    dec.depth = count + one;
                    dec.sel   = SEL_VALUE;
                end
            end
            OP_DUP:
            begin
                if (empty)
                begin
                    dec.status = ST_UNDER;
                end
                else if (full)
                begin
                    dec.status = ST_OVER;
                end
                else
                begin
                    dec.we        = 1'b1;
                    dec.wsrc_read = 1'b1;
                    dec.depth     = count + one;
                    dec.sel       = SEL_READ;
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    dec.status = zero_on_empty ? ST_OK : ST_UNDER;
                end
                else
                begin
                    dec.depth = count - one;
                    dec.sel   = SEL_READ;
                end
            end
            OP_DROP:
            begin
                if (empty)
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.depth = count - one;
                    dec.raddr = count - CNT_W'(2);
                    dec.sel   = (count == one) ? SEL_ZERO : SEL_READ;
                end
            end
            OP_DROP_N:
            begin
                if (drop_count > count)
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.depth = after_n;
                    dec.raddr = after_n - one;
                    dec.sel   = (after_n == '0) ? SEL_ZERO : SEL_READ;
                end
            end
            OP_TOP, OP_POP_OR_TOP:
            begin
                if (empty)
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.sel = SEL_READ;
                    if (opcode_t'(op) == OP_POP_OR_TOP && count > one)
                    begin
                        dec.depth = count - one;
                    end
                end
            end
            OP_NOS:
            begin
                if (count < CNT_W'(2))
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.raddr = count - CNT_W'(2);
                    dec.sel   = SEL_READ;
                end
            end
            OP_PICK:
            begin
                if (off_ext >= count)
                begin
                    dec.status = ST_RANGE;
                end
                else
                begin
                    dec.raddr = count - one - off_ext;
                    dec.sel   = SEL_READ;
                end
            end
            OP_PICK_BOTTOM:
            begin
                if (off_ext >= count)
                begin
                    dec.status = ST_RANGE;
                end
                else
                begin
                    dec.raddr = off_ext;
                    dec.sel   = SEL_READ;
                end
            end
            OP_SET_TOP:
            begin
                if (empty)
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.we    = 1'b1;
                    dec.waddr = count - one;
                    dec.sel   = SEL_VALUE;
                end
            end
            OP_SET_BOTTOM:
            begin
                if (empty)
                begin
                    dec.status = ST_UNDER;
                end
                else
                begin
                    dec.we    = 1'b1;
                    dec.waddr = '0;
                    dec.sel   = SEL_VALUE;
                end
            end
            OP_CLEAR:
            begin
                dec.depth = '0;
            end
            default:
            begin
                dec.depth = count;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- rtl/bls_store.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Stack word store
// One write port and one registered read port, with forwarding of the write
// that lands at the same edge as the read.
// ----------------------------------------------------------------------------
module bls_store #(
    parameter int MAX_SLOTS = bls_pkg::MAX_SLOTS_DEF
) (
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [bls_pkg::CNT_W-1:0]  raddr,
    input  wire logic                       wr_en,
    input  wire logic [bls_pkg::CNT_W-1:0]  waddr,
    input  wire logic                       wsrc_read,
    input  wire logic [bls_pkg::WORD_W-1:0] wvalue,
    output logic      [bls_pkg::WORD_W-1:0] rd_word
);
    import bls_pkg::*;

    localparam int MemDepth = (MAX_SLOTS < CNT_LIMIT) ? MAX_SLOTS : CNT_LIMIT;
    localparam int AddrW    = $clog2(MemDepth);

    logic [WORD_W-1:0] mem [MemDepth];
    logic [WORD_W-1:0] rd_data_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic              fwd_hit_reg;
    logic [WORD_W-1:0] wdata;

    assign rd_word = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign wdata   = wsrc_read ? rd_word : wvalue;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[waddr[AddrW-1:0]] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= mem[raddr[AddrW-1:0]];
            fwd_hit_reg  <= wr_en && (waddr[AddrW-1:0] == raddr[AddrW-1:0]);
            fwd_data_reg <= wdata;
        end
    end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded LIFO stack engine testbench
// Drives stack operations into the slave stream with random gaps, takes the
// results from the master stream under random stalls, and checks every
// result field against a predicted copy of the stack. The slot count is
// changed between phases while the block is idle.
// ----------------------------------------------------------------------------

typedef struct {
    logic [31:0]     data;
    logic [8:0]      depth;
    bls_pkg::status_t status;
} stack_result_t;

class lifo_scoreboard;
    localparam int SLOTS = bls_pkg::MAX_SLOTS_DEF;

    logic [31:0]   words [SLOTS];
    int unsigned   depth_now;
    int unsigned   slots;
    stack_result_t pending[$];
    int unsigned   mismatches;

    function new();
        depth_now  = 0;
        slots      = 256;
        mismatches = 0;
    endfunction

    function void set_slots(logic [8:0] v);
        slots = v;
    endfunction

    function void report(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH: %s", msg);
    endfunction

    function void note_operation(logic [3:0] op, logic [31:0] val, logic [7:0] off,
                                 logic [8:0] cnt, logic zoe);
        int unsigned      d;
        int unsigned      cap;
        logic [31:0]      data;
        bls_pkg::status_t st;
        stack_result_t    r;
        d    = depth_now;
        cap  = (slots > SLOTS) ? SLOTS : slots;
        data = '0;
        st   = bls_pkg::ST_OK;
        case (op)
            bls_pkg::OP_PUSH, bls_pkg::OP_DUP:
            begin
                if (op == bls_pkg::OP_DUP && d == 0)
                    st = bls_pkg::ST_UNDER;
                else if (d >= cap || d >= SLOTS)
                    st = bls_pkg::ST_OVER;
                else
                begin
                    if (op == bls_pkg::OP_DUP)
                        val = words[d-1];
                    words[d]  = val;
                    depth_now = d + 1;
                    data      = val;
                end
            end
            bls_pkg::OP_POP:
            begin
                if (d == 0)
                    st = zoe ? bls_pkg::ST_OK : bls_pkg::ST_UNDER;
                else
                begin
                    data      = words[d-1];
                    depth_now = d - 1;
                end
            end
            bls_pkg::OP_DROP:
            begin
                if (d == 0)
                    st = bls_pkg::ST_UNDER;
                else
                begin
                    depth_now = d - 1;
                    data      = (depth_now != 0) ? words[depth_now-1] : '0;
                end
            end
            bls_pkg::OP_DROP_N:
            begin
                if (cnt > d)
                    st = bls_pkg::ST_UNDER;
                else
                begin
                    depth_now = d - cnt;
                    data      = (depth_now != 0) ? words[depth_now-1] : '0;
                end
            end
            bls_pkg::OP_TOP:
            begin
                if (d == 0)
                    st = bls_pkg::ST_UNDER;
                else
                    data = words[d-1];
            end
            bls_pkg::OP_NOS:
            begin
                if (d < 2)
                    st = bls_pkg::ST_UNDER;
                else
                    data = words[d-2];
            end
            bls_pkg::OP_PICK:
            begin
                if (off >= d)
                    st = bls_pkg::ST_RANGE;
                else
                    data = words[d-1-off];
            end
            bls_pkg::OP_PICK_BOTTOM:
            begin
                if (off >= d)
                    st = bls_pkg::ST_RANGE;
                else
                    data = words[off];
            end
            bls_pkg::OP_SET_TOP:
            begin
                if (d == 0)
                    st = bls_pkg::ST_UNDER;
                else
                begin
                    words[d-1] = val;
                    data       = val;
                end
            end
            bls_pkg::OP_SET_BOTTOM:
            begin
                if (d == 0)
                    st = bls_pkg::ST_UNDER;
                else
                begin
                    words[0] = val;
                    data     = val;
                end
            end
            bls_pkg::OP_POP_OR_TOP:
            begin
                if (d == 0)
                    st = bls_pkg::ST_UNDER;
                else
                begin
                    data = words[d-1];
                    if (d > 1)
                        depth_now = d - 1;
                end
            end
            bls_pkg::OP_CLEAR:
                depth_now = 0;
            default:
                ;
        endcase
        r.data   = (st == bls_pkg::ST_OK) ? data : '0;
        r.depth  = depth_now[8:0];
        r.status = st;
        pending.push_back(r);
    endfunction

    function void check_result(logic [47:0] beat);
        stack_result_t e;
        if (pending.size() == 0)
        begin
            report($sformatf("result %h arrived with no operation pending", beat));
            return;
        end
        e = pending.pop_front();
        if (beat[31:0] !== e.data)
            report($sformatf("data expected %h actual %h", e.data, beat[31:0]));
        if (beat[40:32] !== e.depth)
            report($sformatf("depth expected %0d actual %0d", e.depth, beat[40:32]));
        if (beat[42:41] !== e.status)
            report($sformatf("status expected %0d actual %0d", e.status, beat[42:41]));
    endfunction
endclass

module tb_top;
    import bls_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [CNT_W-1:0]       cfg_data;
    logic                   cfg_valid;
    logic                   cfg_ready;

    lifo_scoreboard board;
    int unsigned    send_run_left;
    bit             send_no_gaps;

    bounded_lifo_stack_engine_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic send_op(input logic [3:0] op, input logic [31:0] val = '0,
                           input logic [7:0] off = '0, input logic [8:0] cnt = '0,
                           input logic zoe = 1'b0);
        int unsigned gap;
        if (send_run_left == 0)
        begin
            send_run_left = $urandom_range(5, 40);
            send_no_gaps  = ($urandom_range(0, 2) == 0);
        end
        send_run_left--;
        gap = send_no_gaps ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, zoe, cnt, off, val, op};
        do @(posedge clk); while (!s_tready);
        board.note_operation(op, val, off, cnt, zoe);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_slots(input logic [8:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_slots(v);
    endtask

    task automatic run_random(input int unsigned n, input int unsigned push_pct);
        int unsigned d;
        logic [3:0]  op;
        logic [7:0]  off;
        logic [8:0]  cnt;
        repeat (n)
        begin
            d = board.depth_now;
            if ($urandom_range(0, 99) < push_pct)
                op = OP_PUSH;
            else if ($urandom_range(0, 19) == 0)
                op = 4'($urandom_range(OP_CLEAR, 15));
            else
                op = 4'($urandom_range(OP_POP, OP_POP_OR_TOP));
            if (d > 0 && $urandom_range(0, 3) != 0)
                off = 8'($urandom_range(0, d - 1));
            else
                off = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 9))
                7:       cnt = 9'(d);
                8, 9:    cnt = 9'($urandom_range(0, 256));
                default: cnt = 9'($urandom_range(0, (d < 4) ? d : 4));
            endcase
            send_op(op, $urandom, off, cnt, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        int unsigned stall;
        int unsigned run_left;
        bit          no_stalls;
        m_tready = 1'b0;
        run_left = 0;
        @(posedge rst_n);
        forever
        begin
            if (run_left == 0)
            begin
                run_left  = $urandom_range(5, 40);
                no_stalls = ($urandom_range(0, 2) == 0);
            end
            run_left--;
            stall = no_stalls ? 0 : $urandom_range(0, 16);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            board.check_result(m_tdata);
        end
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        board         = new();
        send_run_left = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty stack cases under a small capacity, then pushes to reach overflow quickly.
        write_slots(9'd3);
        send_op(OP_POP, 32'h1, 8'd0, 9'd0, 1'b0);
        send_op(OP_POP, 32'h1, 8'd0, 9'd0, 1'b1);
        send_op(OP_DUP);
        send_op(OP_DROP);
        send_op(OP_TOP);
        send_op(OP_NOS);
        send_op(OP_PICK, '0, 8'd0);
        send_op(OP_PICK_BOTTOM, '0, 8'd0);
        send_op(OP_SET_TOP, 32'h1234_5678);
        send_op(OP_SET_BOTTOM, 32'h1234_5678);
        send_op(OP_POP_OR_TOP);
        send_op(OP_DROP_N, '0, 8'd0, 9'd1);
        send_op(OP_DROP_N, '0, 8'd0, 9'd0);
        send_op(OP_PUSH, 32'h8000_0000);
        send_op(OP_PUSH, 32'h7FFF_FFFF);
        send_op(OP_NOS);
        send_op(OP_PUSH, 32'hFFFF_FFFF);
        send_op(OP_PUSH, 32'h0000_0000);
        send_op(OP_DUP);
        send_op(OP_PICK, '0, 8'd255);
        send_op(OP_PICK, '0, 8'd2);
        send_op(OP_PICK_BOTTOM, '0, 8'd2);
        send_op(OP_SET_BOTTOM, 32'h5A5A_A5A5);
        send_op(OP_SET_TOP, 32'hDEAD_BEEF);
        send_op(4'd13);
        send_op(4'd14);
        send_op(4'd15);
        send_op(OP_DROP_N, '0, 8'd0, 9'd4);
        send_op(OP_DROP, '0);

        // Capacity lowered below the current depth keeps the elements.
        write_slots(9'd1);
        send_op(OP_PUSH, 32'h0BAD_F00D);
        send_op(OP_DUP);
        send_op(OP_POP_OR_TOP);
        send_op(OP_POP_OR_TOP);
        send_op(OP_CLEAR);

        write_slots(9'd256);
        run_random(300, 88);
        send_op(OP_DROP_N, '0, 8'd0, 9'(board.depth_now));
        run_random(40, 92);
        write_slots(9'd1);
        run_random(50, 40);
        write_slots(9'd2);
        run_random(50, 45);
        write_slots(9'd17);
        run_random(90, 55);
        write_slots(9'($urandom_range(1, 256)));
        run_random(85, 55);

        wait_drained();
        repeat (16) @(posedge clk);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ----- filelist.f -----
rtl/bls_pkg.sv
rtl/bls_decode.sv
rtl/bls_store.sv
rtl/bounded_lifo_stack_engine_top.sv
sim/tb_top.sv
